// ===== rtl/core/mck_pkg.sv =====
// Shared types, constants and the character classifier for the Morse keyer.
package mck_pkg;

	localparam int unsigned DOT_UNIT_W = 16;
	localparam int unsigned UNITS_W = 3;
	localparam int unsigned MS_W = 18;
	localparam int unsigned MAX_ELEMS = 5;
	localparam int unsigned LEN_W = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [DOT_UNIT_W-1:0] DOT_UNIT_RESET = 16'd500;

	localparam logic [UNITS_W-1:0] DOT_UNITS = 3'd1;
	localparam logic [UNITS_W-1:0] DASH_UNITS = 3'd3;
	localparam logic [UNITS_W-1:0] ELEM_GAP_UNITS = 3'd1;
	localparam logic [UNITS_W-1:0] LETTER_GAP_UNITS = 3'd2;
	localparam logic [UNITS_W-1:0] WORD_GAP_UNITS = 3'd4;

	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UZ = 8'h5A;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_LZ = 8'h7A;
	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_9 = 8'h39;
	localparam logic [7:0] CASE_OFFSET = 8'h20;
	localparam logic [5:0] DIGIT_BASE = 6'd26;

	// One classified character: element count and dash mask, element 0 in bit 0.
	typedef struct packed {
		logic                 known;
		logic [LEN_W-1:0]     len;
		logic [MAX_ELEMS-1:0] dash;
	} entry_t;

	// {len, dash mask}; letters a..z, then digits 0..9.
	localparam logic [LEN_W+MAX_ELEMS-1:0] CODE_TABLE [0:35] = '{
		{3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
		{3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
		{3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
		{3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
		{3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
		{3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
		{3'd4, 5'b01101}, {3'd4, 5'b00011},
		{3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
		{3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
		{3'd5, 5'b00111}, {3'd5, 5'b01111}
	};

	function automatic entry_t classify(input logic [7:0] c);
		logic [7:0] f;
		logic [5:0] slot;
		logic       hit;
		entry_t     e;
		f = c;
		slot = '0;
		hit = 1'b0;
		if (c >= CHAR_UA && c <= CHAR_UZ) begin
			f = c + CASE_OFFSET;
		end
		if (f >= CHAR_LA && f <= CHAR_LZ) begin
			slot = 6'(f - CHAR_LA);
			hit = 1'b1;
		end else if (f >= CHAR_0 && f <= CHAR_9) begin
			slot = 6'(f - CHAR_0) + DIGIT_BASE;
			hit = 1'b1;
		end
		e.known = hit;
		e.len = hit ? CODE_TABLE[slot][LEN_W+MAX_ELEMS-1:MAX_ELEMS] : '0;
		e.dash = hit ? CODE_TABLE[slot][MAX_ELEMS-1:0] : '0;
		return e;
	endfunction

endpackage

// ===== rtl/core/mck_front.sv =====
// Front end: accepts character beats and classifies them into queue entries.
module mck_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [7:0]      character,
	output logic            full,
	input  logic            q_full,
	output logic            q_wr,
	output mck_pkg::entry_t q_entry
);
	import mck_pkg::*;

	logic   valid_s1;
	entry_t entry_s1;
	logic   accept;

	assign q_wr = valid_s1 && !q_full;
	assign full = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= classify(character);
		end
	end

endmodule

// ===== rtl/core/mck_queue.sv =====
// Short entry queue that decouples the classifier from the segment sequencer.
module mck_queue #(
	parameter int unsigned DEPTH = mck_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  mck_pkg::entry_t wr_entry,
	output logic            full,
	output logic            valid,
	input  logic            rd,
	output mck_pkg::entry_t rd_entry
);
	import mck_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (count_q == FULL_CNT);
	assign valid = (count_q != '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== rtl/core/mck_back.sv =====
// Back end: emits an entry's keying segments, one per cycle unless stalled.
module mck_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [mck_pkg::DOT_UNIT_W-1:0]       dot_unit,
	input  logic                                 q_valid,
	input  mck_pkg::entry_t                      q_entry,
	output logic                                 q_rd,
	input  logic                                 out_pop,
	output logic                                 out_valid,
	output logic                                 lamp_on,
	output logic [mck_pkg::UNITS_W-1:0]          duration_units,
	output logic [mck_pkg::MS_W-1:0]             duration_ms,
	output logic                                 known_symbol,
	output logic                                 last_segment
);
	import mck_pkg::*;

	logic               busy_q;
	entry_t             cur_q;
	logic [LEN_W-1:0]   elem_q;
	logic               phase_q;
	logic               out_valid_q;

	logic               seg_lamp;
	logic [UNITS_W-1:0] seg_units;
	logic               seg_last;
	logic               adv;
	logic               load;

	always_comb begin
		seg_lamp = 1'b0;
		seg_units = ELEM_GAP_UNITS;
		seg_last = 1'b0;
		if (!cur_q.known) begin
			seg_units = WORD_GAP_UNITS;
			seg_last = 1'b1;
		end else if (elem_q == cur_q.len) begin
			seg_units = LETTER_GAP_UNITS;
			seg_last = 1'b1;
		end else if (!phase_q) begin
			seg_lamp = 1'b1;
			seg_units = cur_q.dash[elem_q] ? DASH_UNITS : DOT_UNITS;
		end
	end

	// Advance whenever the output register is free or being drained this cycle.
	assign adv = busy_q && (!out_valid_q || out_pop);
	assign load = (!busy_q || (adv && seg_last)) && q_valid;
	assign q_rd = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			elem_q <= '0;
			phase_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				elem_q <= '0;
				phase_q <= 1'b0;
			end else if (adv && seg_last) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				if (phase_q) begin
					phase_q <= 1'b0;
					elem_q <= elem_q + 1'b1;
				end else begin
					phase_q <= 1'b1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_entry;
		end
		if (adv) begin
			lamp_on <= seg_lamp;
			duration_units <= seg_units;
			duration_ms <= MS_W'({{(MS_W-UNITS_W){1'b0}}, seg_units}
				* {{(MS_W-DOT_UNIT_W){1'b0}}, dot_unit});
			known_symbol <= cur_q.known;
			last_segment <= seg_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/morse_char_keyer_core.sv =====
// Morse character keyer: one segment result beat per cycle unless the output stalls.
// Path: a beat is classified into the front-end register, then written to the queue
// and loaded by the back end. Throughput: one segment per cycle unless output stalls,
// and a character gives 1 to 11 segments (digits 11) from the back-end sequencer.
// Reset: arst_n clears the front end, queue and sequencer; dot_unit_q returns to 500.
module morse_char_keyer_core #(
	parameter int unsigned QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mck_pkg::DOT_UNIT_W-1:0]     cfg_wr_data,
	input  logic                               push,
	output logic                               full,
	input  logic [7:0]                         character,
	output logic                               empty,
	input  logic                               pop,
	output logic                               lamp_on,
	output logic [mck_pkg::UNITS_W-1:0]        duration_units,
	output logic [mck_pkg::MS_W-1:0]           duration_ms,
	output logic                               known_symbol,
	output logic                               last_segment
);
	import mck_pkg::*;

	logic [DOT_UNIT_W-1:0] dot_unit_q;
	logic                  q_wr;
	logic                  q_full;
	logic                  q_valid;
	logic                  q_rd;
	entry_t                wr_entry;
	entry_t                rd_entry;
	logic                  out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_unit_q <= DOT_UNIT_RESET;
		end else if (cfg_wr_en) begin
			dot_unit_q <= cfg_wr_data;
		end
	end

	mck_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.character(character),
		.full     (full),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_entry  (wr_entry)
	);

	mck_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_entry(wr_entry),
		.full    (q_full),
		.valid   (q_valid),
		.rd      (q_rd),
		.rd_entry(rd_entry)
	);

	mck_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.dot_unit      (dot_unit_q),
		.q_valid       (q_valid),
		.q_entry       (rd_entry),
		.q_rd          (q_rd),
		.out_pop       (pop && out_valid),
		.out_valid     (out_valid),
		.lamp_on       (lamp_on),
		.duration_units(duration_units),
		.duration_ms   (duration_ms),
		.known_symbol  (known_symbol),
		.last_segment  (last_segment)
	);

	assign empty = !out_valid;

endmodule

// ===== rtl/core/mck_checker.sv =====
// Port-level checks for the Morse keyer, bound to the top level.
module mck_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             full,
	input logic                             empty,
	input logic                             pop,
	input logic                             lamp_on,
	input logic [mck_pkg::UNITS_W-1:0]      duration_units,
	input logic                             known_symbol,
	input logic                             last_segment
);
	import mck_pkg::*;

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("keyer not idle in reset");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(lamp_on) && $stable(duration_units)
		&& $stable(last_segment) && $stable(known_symbol))
		else $error("stalled result beat changed");

	a_word_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !known_symbol |-> last_segment && !lamp_on
		&& duration_units == WORD_GAP_UNITS)
		else $error("unknown character gave a bad word gap");

	a_keyed_seg: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && lamp_on |-> known_symbol && !last_segment
		&& (duration_units == DOT_UNITS || duration_units == DASH_UNITS))
		else $error("keyed segment has bad shape");

endmodule

bind morse_char_keyer_core mck_checker u_mck_checker (.*);
